@@ rtl/qph_pkg.sv @@
// Shared types and constants for the quadratic-probe hash table.
// No dependencies; imported by every module of the block.
package qph_pkg;

    localparam int TABLE_SIZE = 16;  // must be a power of two
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2
    } mark_t;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic             rd_en;
        idx_t             rd_addr;
        logic             wr_en;
        idx_t             wr_addr;
        mark_t            wr_mark;
        logic [KEY_W-1:0] wr_key;
    } mem_req_t;

    typedef struct packed {
        mark_t            mark;
        logic [KEY_W-1:0] key;
    } mem_rsp_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
    } result_t;

endpackage

@@ rtl/quadratic_probe_hash_table.sv @@
// Top level of the quadratic-probe hash table: sequencer, slot memory, output register.
// Depends on qph_pkg, qph_slot_ram and qph_ctrl.
//
//  Channel  | Ports                               | Dir | Transaction
//  ---------+-------------------------------------+-----+-----------------------------
//  command  | s_valid s_ready s_cmd s_key         | in  | insert / search / delete
//  result   | m_valid m_ready m_status m_slot_... | out | one status + slot per command
//
// Probing: a command visits k slots (1 <= k <= 16), reading them one by one through the
// single read port of the slot memory. An unused command code ends on its first probe.
// Reset: aresetn (synchronous, active low) clears the per-slot valid flops at once,
// so every slot reads as empty on the next cycle; no clearing pass is needed.
// Stalls: a result waits in the output register while the next command is accepted;
// if that command finishes before the register drains, the sequencer holds it.
module quadratic_probe_hash_table
    import qph_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [KEY_W-1:0]    s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot_index
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;
    result_t  res;
    logic     res_valid;
    logic     out_free;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_index_reg;

    // Output register can take a new result when empty or draining this cycle
    assign out_free = !m_valid_reg || m_ready;

    qph_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_key     (s_key),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    qph_slot_ram u_slot_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rsp     (mem_rsp)
    );

    // Advance the output register; drop valid once the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_status_reg     <= res.status;
            m_slot_index_reg <= res.slot_index;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_index_reg;

    // A result is only handed over when the output register has room
    a_res_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result produced while output register is full");

    // A failed command reports slot zero
    a_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_slot_index == '0))
        else $error("nonzero slot index on failed command");

    // A probe follows every accepted command before the next one is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted back to back without probing");

    // Memory writes happen only while a command is in flight
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (!s_ready && res_valid || !s_ready && !out_free))
        else $error("slot memory written outside a probe");

endmodule

@@ rtl/qph_slot_ram.sv @@
// Slot store: key and mark memory, one read and one write port, registered read.
// Depends on qph_pkg. Per-entry valid flops make unwritten slots read as empty.
module qph_slot_ram
    import qph_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
    mark_t                 mark_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [KEY_W-1:0]      rd_key_reg;
    mark_t                 rd_mark_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            key_mem[req.wr_addr]  <= req.wr_key;
            mark_mem[req.wr_addr] <= req.wr_mark;
        end
        if (req.rd_en) begin
            rd_key_reg  <= key_mem[req.rd_addr];
            rd_mark_reg <= valid_reg[req.rd_addr] ? mark_mem[req.rd_addr] : MARK_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rsp.mark = rd_mark_reg;
    assign rsp.key  = rd_key_reg;

endmodule

@@ rtl/qph_ctrl.sv @@
// Probe sequencer: walks the quadratic probe chain, one slot read per cycle while probing.
// Depends on qph_pkg; drives qph_slot_ram and hands results to the top level.
module qph_ctrl
    import qph_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] s_cmd,
    input  logic [KEY_W-1:0] s_key,
    input  logic             out_free,
    output logic             res_valid,
    output result_t          res,
    output mem_req_t         mem_req,
    input  mem_rsp_t         mem_rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_HOLD  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    idx_t             cur_addr_reg;
    idx_t             step_idx_reg;
    result_t          pend_reg;

    idx_t    next_addr;
    logic    last_probe;
    logic    done;
    result_t probe_res;
    logic    accept;
    logic    rd_en;
    idx_t    rd_addr;
    logic    wr_en;
    mark_t   wr_mark;

    assign accept     = s_valid && s_ready;
    // offset(i+1) = offset(i) + 2i + 1, all mod TABLE_SIZE
    assign next_addr  = cur_addr_reg + IDX_W'({step_idx_reg, 1'b1});
    assign last_probe = (step_idx_reg == idx_t'(TABLE_SIZE - 1));

    // Field order: rd_en, rd_addr, wr_en, wr_addr, wr_mark, wr_key
    assign mem_req = {rd_en, rd_addr, wr_en, cur_addr_reg, wr_mark, key_reg};

    // Evaluate the slot whose read data is on mem_rsp this cycle
    always_comb begin
        done                 = 1'b0;
        probe_res.status     = ST_MISSING;
        probe_res.slot_index = '0;
        wr_en                = 1'b0;
        wr_mark              = MARK_USED;
        case (cmd_reg)
            CMD_INSERT: begin
                if (mem_rsp.mark != MARK_USED) begin
                    done                 = 1'b1;
                    probe_res.status     = ST_OK;
                    probe_res.slot_index = SLOT_W'(cur_addr_reg);
                    wr_en                = (state_reg == S_PROBE);
                end else if (last_probe) begin
                    done             = 1'b1;
                    probe_res.status = ST_FULL;
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                if (mem_rsp.mark == MARK_EMPTY) begin
                    done = 1'b1;
                end else if (mem_rsp.mark == MARK_USED && mem_rsp.key == key_reg) begin
                    done                 = 1'b1;
                    probe_res.status     = ST_OK;
                    probe_res.slot_index = SLOT_W'(cur_addr_reg);
                    wr_mark              = MARK_GONE;
                    wr_en                = (state_reg == S_PROBE) && (cmd_reg == CMD_DELETE);
                end else if (last_probe) begin
                    done = 1'b1;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        res        = probe_res;
        rd_en      = 1'b0;
        rd_addr    = next_addr;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid;
                rd_addr = s_key[IDX_W-1:0];
                if (s_valid) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                rd_en = !done;
                if (done) begin
                    res_valid  = out_free;
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                res       = pend_reg;
                res_valid = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_cmd;
            key_reg      <= s_key;
            cur_addr_reg <= s_key[IDX_W-1:0];
            step_idx_reg <= '0;
        end else if (state_reg == S_PROBE && !done) begin
            cur_addr_reg <= next_addr;
            step_idx_reg <= step_idx_reg + idx_t'(1);
        end
        if (state_reg == S_PROBE && done) begin
            pend_reg <= probe_res;
        end
    end

endmodule
